// ----- sv/dni_pkg.sv -----
// Shared types and constants for the DMA network interface.
`timescale 1ns / 1ps

package dni_pkg;

   localparam int FLIT_W   = 16;
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 16;
   localparam int FUNC_W   = 2;
   localparam int CSR_W    = 32;
   localparam int CSR_AW   = 3;
   localparam int REQ_BITS = 88;
   localparam int RSP_BITS = 104;

   localparam logic [ADDR_W-1:0] ADDR_STEP     = ADDR_W'(2);
   localparam logic [LEN_W-1:0]  TIMESLICE_RST = LEN_W'(16);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK = 2'd0,
      FUNC_SEND = 2'd1,
      FUNC_RECV = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      MODE_ROUND = 2'd0,
      MODE_SEND  = 2'd1,
      MODE_RECV  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PH_WAIT   = 2'd0,
      PH_COPY   = 2'd1,
      PH_FINISH = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_SEND = 2'd1,
      KIND_RECV = 2'd2
   } kind_type;

   // Register index of timeslice on the configuration port
   localparam logic CSR_IDX_TIMESLICE = 1'b0;

   // Result beat; last member lands in the lowest bits
   typedef struct packed {
      logic              recv_busy;
      logic              send_busy;
      logic [ADDR_W-1:0] rd_addr;
      logic [FLIT_W-1:0] wr_data;
      logic [ADDR_W-1:0] wr_addr;
      logic              wr_valid;
      logic              in_pop;
      logic [FLIT_W-1:0] out_flit;
      logic              out_valid;
   } result_type;

endpackage

// ----- sv/dni_core.sv -----
// Arbiter, receiver and sender state with their one-beat update.
`timescale 1ns / 1ps

module dni_core import dni_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  func_type          func,
   input  logic [ADDR_W-1:0] cmd_addr,
   input  logic [LEN_W-1:0]  cmd_len,
   input  logic [FLIT_W-1:0] mem_flit,
   input  logic [FLIT_W-1:0] in_flit,
   input  logic              in_valid,
   input  logic [LEN_W-1:0]  timeslice,
   output result_type        result
);

   mode_type          arb_mode_ff, arb_mode_in;
   logic              recv_prio_ff, recv_prio_in;
   logic [LEN_W-1:0]  hold_ff, hold_in;
   phase_type         send_phase_ff, send_phase_in;
   phase_type         recv_phase_ff, recv_phase_in;
   logic [ADDR_W-1:0] send_ptr_ff, send_ptr_in;
   logic [LEN_W-1:0]  send_left_ff, send_left_in;
   logic [ADDR_W-1:0] recv_ptr_ff, recv_ptr_in;
   logic [LEN_W-1:0]  recv_left_ff, recv_left_in;
   kind_type          pend_kind_ff, pend_kind_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [LEN_W-1:0]  pend_len_ff, pend_len_in;

   logic s_copy, r_copy, slice_up;

   assign s_copy   = (send_phase_ff == PH_COPY);
   assign r_copy   = (recv_phase_ff == PH_COPY);
   assign slice_up = (hold_ff >= timeslice);

   always_comb begin
      arb_mode_in   = arb_mode_ff;
      recv_prio_in  = recv_prio_ff;
      hold_in       = hold_ff;
      send_phase_in = send_phase_ff;
      recv_phase_in = recv_phase_ff;
      send_ptr_in   = send_ptr_ff;
      send_left_in  = send_left_ff;
      recv_ptr_in   = recv_ptr_ff;
      recv_left_in  = recv_left_ff;
      pend_kind_in  = pend_kind_ff;
      pend_addr_in  = pend_addr_ff;
      pend_len_in   = pend_len_ff;
      result        = '0;

      if (step) begin
         unique case (func)
            FUNC_SEND, FUNC_RECV: begin
               pend_kind_in = (func == FUNC_SEND) ? KIND_SEND : KIND_RECV;
               pend_addr_in = cmd_addr;
               pend_len_in  = cmd_len;
            end
            FUNC_TICK: begin
               // arbiter: release on finish or on an expired slice with the other side waiting
               if (arb_mode_ff == MODE_SEND || arb_mode_ff == MODE_RECV) begin
                  if ((arb_mode_ff == MODE_SEND &&
                       (send_phase_ff == PH_FINISH || (slice_up && r_copy))) ||
                      (arb_mode_ff == MODE_RECV &&
                       (recv_phase_ff == PH_FINISH || (slice_up && s_copy)))) begin
                     hold_in      = '0;
                     arb_mode_in  = MODE_ROUND;
                     recv_prio_in = ~recv_prio_ff;
                  end else if (hold_ff != '1) begin
                     hold_in = hold_ff + LEN_W'(1);
                  end
               end else if (recv_prio_ff) begin
                  if (r_copy)      arb_mode_in = MODE_RECV;
                  else if (s_copy) arb_mode_in = MODE_SEND;
               end else begin
                  if (s_copy)      arb_mode_in = MODE_SEND;
                  else if (r_copy) arb_mode_in = MODE_RECV;
               end

               // receiver
               if (r_copy) begin
                  pend_kind_in = KIND_NONE;
                  if (arb_mode_in == MODE_RECV && in_valid) begin
                     result.in_pop   = 1'b1;
                     result.wr_valid = 1'b1;
                     result.wr_addr  = recv_ptr_ff;
                     result.wr_data  = in_flit;
                     recv_ptr_in     = recv_ptr_ff + ADDR_STEP;
                     recv_left_in    = recv_left_ff - LEN_W'(1);
                     if (recv_left_in == '0) recv_phase_in = PH_FINISH;
                  end
               end else if (recv_phase_ff == PH_FINISH) begin
                  recv_phase_in = PH_WAIT;
               end else begin
                  recv_phase_in = PH_WAIT;
                  if (pend_kind_ff == KIND_RECV) begin
                     recv_ptr_in   = pend_addr_ff;
                     recv_left_in  = pend_len_ff;
                     recv_phase_in = PH_COPY;
                  end
               end

               // sender sees the pending job after the receiver had its turn
               if (s_copy) begin
                  pend_kind_in = KIND_NONE;
                  if (arb_mode_in == MODE_SEND) begin
                     result.out_valid = 1'b1;
                     result.out_flit  = mem_flit;
                     send_ptr_in      = send_ptr_ff + ADDR_STEP;
                     send_left_in     = send_left_ff - LEN_W'(1);
                     if (send_left_in == '0) send_phase_in = PH_FINISH;
                  end
               end else if (send_phase_ff == PH_FINISH) begin
                  send_ptr_in   = '0;
                  send_left_in  = '0;
                  send_phase_in = PH_WAIT;
               end else begin
                  send_phase_in = PH_WAIT;
                  if (pend_kind_in == KIND_SEND) begin
                     send_ptr_in   = pend_addr_ff;
                     send_left_in  = pend_len_ff;
                     send_phase_in = PH_COPY;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      result.rd_addr   = send_ptr_in;
      result.send_busy = (send_phase_in != PH_WAIT);
      result.recv_busy = (recv_phase_in != PH_WAIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arb_mode_ff   <= MODE_ROUND;
         recv_prio_ff  <= 1'b0;
         hold_ff       <= '0;
         send_phase_ff <= PH_WAIT;
         recv_phase_ff <= PH_WAIT;
         send_ptr_ff   <= '0;
         send_left_ff  <= '0;
         recv_ptr_ff   <= '0;
         recv_left_ff  <= '0;
         pend_kind_ff  <= KIND_NONE;
         pend_addr_ff  <= '0;
         pend_len_ff   <= '0;
      end else begin
         arb_mode_ff   <= arb_mode_in;
         recv_prio_ff  <= recv_prio_in;
         hold_ff       <= hold_in;
         send_phase_ff <= send_phase_in;
         recv_phase_ff <= recv_phase_in;
         send_ptr_ff   <= send_ptr_in;
         send_left_ff  <= send_left_in;
         recv_ptr_ff   <= recv_ptr_in;
         recv_left_ff  <= recv_left_in;
         pend_kind_ff  <= pend_kind_in;
         pend_addr_ff  <= pend_addr_in;
         pend_len_ff   <= pend_len_in;
      end
   end

endmodule

// ----- sv/dma_network_interface.sv -----
// Top level of the DMA network interface: stream ports, result register, timeslice CSR.
//
// Each request beat is either a command (post a send or receive job with a start
// byte address and a flit count, 0 meaning 65536) or one clock tick of the
// interface. A tick runs the memory-port arbiter, then the receiver, then the
// sender, and moves at most one 16-bit flit per side; addresses advance by 2 per
// flit. Every request beat produces exactly one response beat carrying the flit
// traffic of that tick plus the send address whose memory flit must arrive with
// the next tick. Throughput is one beat per cycle: the whole update runs in a
// single pass from the accepted request into the response register, and a new
// request is taken whenever that register is empty or is being drained in the
// same cycle. The timeslice register (byte address 0, reset 16) sets how many
// ticks a side may hold memory before a waiting side preempts; write it only
// while no beats are in flight.
`timescale 1ns / 1ps

module dma_network_interface import dni_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // request stream
   input  logic                req_tvalid,
   output logic                req_tready,
   // tdata: cmd_addr[31:0], cmd_len[47:32], mem_flit[63:48], in_flit[79:64],
   //        in_valid[80], zero[87:81]
   input  logic [REQ_BITS-1:0] req_tdata,
   // tuser: func[1:0]
   input  logic [FUNC_W-1:0]   req_tuser,
   // response stream
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // tdata: out_valid[0], out_flit[16:1], in_pop[17], wr_valid[18], wr_addr[50:19],
   //        wr_data[66:51], rd_addr[98:67], send_busy[99], recv_busy[100], zero[103:101]
   output logic [RSP_BITS-1:0] rsp_tdata,
   // configuration port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_W-1:0]    csr_pwdata,
   output logic [CSR_W-1:0]    csr_prdata,
   output logic                csr_pready
);

   localparam int RES_W = $bits(result_type);

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;
   result_type        result;
   logic [LEN_W-1:0]  timeslice_ff;
   logic              step;
   logic              csr_hit;

   // Take a new beat whenever the response slot is empty or frees up this cycle
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign step       = req_tvalid & req_tready;

   dni_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .func      (func_type'(req_tuser)),
      .cmd_addr  (req_tdata[ADDR_W-1:0]),
      .cmd_len   (req_tdata[ADDR_W +: LEN_W]),
      .mem_flit  (req_tdata[ADDR_W+LEN_W +: FLIT_W]),
      .in_flit   (req_tdata[ADDR_W+LEN_W+FLIT_W +: FLIT_W]),
      .in_valid  (req_tdata[ADDR_W+LEN_W+2*FLIT_W]),
      .timeslice (timeslice_ff),
      .result    (result)
   );

   // Hold the response until taken; reload on every accepted request
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step)            rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_BITS - RES_W)'(0), rsp_data_ff};

   // CSR: one register, word index taken from paddr bit 2
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == CSR_IDX_TIMESLICE);

   always_ff @(posedge clock) begin
      if (reset) begin
         timeslice_ff <= TIMESLICE_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         timeslice_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? {(CSR_W - LEN_W)'(0), timeslice_ff} : '0;

endmodule

// ----- sv/dni_checker.sv -----
// Port-level checks for the DMA network interface, bound to the top level.
`timescale 1ns / 1ps

module dni_checker import dni_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata
);

   // Stalled response beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Pop and memory write always move together
   a_pop_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17] == rsp_tdata[18])
      else $error("in_pop and wr_valid disagree");

   // Idle flit fields read zero
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] || rsp_tdata[16:1] == '0) &&
                     (rsp_tdata[18] || (rsp_tdata[50:19] == '0 && rsp_tdata[66:51] == '0)))
      else $error("unused flit fields not zero");

   // A sent flit leaves the sender busy, a written flit leaves the receiver busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[0] || rsp_tdata[99]) && (!rsp_tdata[18] || rsp_tdata[100]))
      else $error("transfer reported with idle machine");

   // Nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind dma_network_interface dni_checker u_dni_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
